// ===== rtl/core/udp_eo_pkg.sv =====
`default_nettype none
package udp_eo_pkg;

  localparam int DataWidth  = 32;
  localparam int LimitWidth = 16;
  localparam int AddrWidth  = 48;
  localparam int TxUpWidth  = 32;
  localparam int TxLoWidth  = 64;
  localparam int OutSrcWidth = 8;

  localparam int DefEndpointEntries = 64;
  localparam int DefTxnEntries      = 32;
  localparam int DefSourceBits      = 8;

  localparam logic [LimitWidth-1:0] EndpointLimitReset = 16'd30;
  localparam logic [LimitWidth-1:0] TxnLimitReset      = 16'd40;

  typedef enum logic [1:0] {
    OP_OUTBOUND = 2'd0,
    OP_INBOUND  = 2'd1,
    OP_GONE     = 2'd2,
    OP_SWEEP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    V_SEND    = 2'd0,
    V_DELIVER = 2'd1,
    V_DROP    = 2'd2,
    V_NONE    = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    R_NONE      = 3'd0,
    R_COLLISION = 3'd1,
    R_TXID_MISS = 3'd2,
    R_EP_MISS   = 3'd3,
    R_FULL      = 3'd4
  } reason_t;

  localparam logic [1:0] KindRequest = 2'd0;

  localparam logic RegEndpointLimit = 1'b0;
  localparam logic RegTxnLimit      = 1'b1;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // commands broadcast to the endpoint cells
  typedef struct packed {
    logic claim;
    logic touch;
    logic touch_same_owner;
    logic drop_source;
    logic age;
  } ep_cmd_t;

  // commands broadcast to the transaction cells
  typedef struct packed {
    logic write_hit;
    logic claim;
    logic consume;
    logic age;
  } txn_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/udp_eo_ep_cell.sv =====
`default_nettype none
module udp_eo_ep_cell
  import udp_eo_pkg::*;
#(
  parameter int SrcW = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ep_cmd_t               cmd,
  input  wire logic [AddrWidth-1:0]  addr,
  input  wire logic [SrcW-1:0]       src,
  input  wire logic [DataWidth-1:0]  now,
  input  wire logic [LimitWidth-1:0] limit,
  input  wire logic                  free_in,
  output logic                       free_out,
  input  wire logic                  hit_in,
  output logic                       hit_out,
  input  wire logic [SrcW-1:0]       owner_in,
  output logic      [SrcW-1:0]       owner_out
);

  logic                 valid;
  logic [AddrWidth-1:0] address;
  logic [SrcW-1:0]      owner;
  logic [DataWidth-1:0] last_seen;
  logic                 match;
  logic                 take;
  logic [DataWidth-1:0] idle;

  assign match     = valid && (address == addr);
  assign take      = cmd.claim && !valid && !free_in;
  assign idle      = now - last_seen;
  assign free_out  = free_in || !valid;
  assign hit_out   = hit_in || match;
  assign owner_out = owner_in | (match ? owner : '0);

  // hold the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (cmd.drop_source && valid && owner == src) begin
      valid <= 1'b0;
    end else if (cmd.age && valid && idle > {{(DataWidth-LimitWidth){1'b0}}, limit}) begin
      valid <= 1'b0;
    end
  end

  // claim or refresh the entry
  always_ff @(posedge clk) begin
    if (take) begin
      address   <= addr;
      owner     <= src;
      last_seen <= now;
    end else if (cmd.touch && match && (!cmd.touch_same_owner || owner == src)) begin
      last_seen <= now;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/udp_eo_txn_cell.sv =====
`default_nettype none
module udp_eo_txn_cell
  import udp_eo_pkg::*;
#(
  parameter int SrcW = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire txn_cmd_t              cmd,
  input  wire logic [TxUpWidth-1:0]  tx_up,
  input  wire logic [TxLoWidth-1:0]  tx_lo,
  input  wire logic [SrcW-1:0]       src,
  input  wire logic [DataWidth-1:0]  now,
  input  wire logic [LimitWidth-1:0] limit,
  input  wire logic                  free_in,
  output logic                       free_out,
  input  wire logic                  hit_in,
  output logic                       hit_out,
  input  wire logic [SrcW-1:0]       src_in,
  output logic      [SrcW-1:0]       src_out
);

  logic                 valid;
  logic [TxUpWidth-1:0] id_up;
  logic [TxLoWidth-1:0] id_lo;
  logic [SrcW-1:0]      owner;
  logic [DataWidth-1:0] created;
  logic                 match;
  logic                 take;
  logic [DataWidth-1:0] age_val;

  assign match    = valid && (id_up == tx_up) && (id_lo == tx_lo);
  assign take     = cmd.claim && !valid && !free_in;
  assign age_val  = now - created;
  assign free_out = free_in || !valid;
  assign hit_out  = hit_in || match;
  assign src_out  = src_in | (match ? owner : '0);

  // hold the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (cmd.consume && match) begin
      valid <= 1'b0;
    end else if (cmd.age && valid &&
                 age_val > {{(DataWidth-LimitWidth){1'b0}}, limit}) begin
      valid <= 1'b0;
    end
  end

  // record a new or repeated transaction
  always_ff @(posedge clk) begin
    if (take || (cmd.write_hit && match)) begin
      id_up   <= tx_up;
      id_lo   <= tx_lo;
      owner   <= src;
      created <= now;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/udp_endpoint_ownership_demux.sv =====
`default_nettype none
// Endpoint ownership demux for many inner sources sharing one UDP port.
// Raise start with the item fields while busy is low; busy then goes high
// while the endpoint and transaction cells compare the item in parallel,
// and the result is shown on the next cycle with done high for exactly one
// cycle. Every operation, including source-gone and age sweep, completes
// this way, because each table entry is its own cell that acts on the
// broadcast command in the same cycle. The receiver cannot stall: sample
// the result whenever done is high. The drop counters stay on their ports
// between results.
module udp_endpoint_ownership_demux
  import udp_eo_pkg::*;
#(
  parameter int ENDPOINT_ENTRIES = DefEndpointEntries,
  parameter int TXN_ENTRIES      = DefTxnEntries,
  parameter int SOURCE_BITS      = DefSourceBits
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] now_time,
  input  wire logic [7:0]  source_id,
  input  wire logic [31:0] peer_ip,
  input  wire logic [15:0] peer_port,
  input  wire logic        is_stun,
  input  wire logic [1:0]  stun_kind,
  input  wire logic [31:0] txid_upper,
  input  wire logic [63:0] txid_lower,
  output logic             done,
  output logic [1:0]       verdict,
  output logic [2:0]       drop_reason,
  output logic [7:0]       deliver_source,
  output logic [31:0]      collision_drops,
  output logic [31:0]      txid_miss_drops,
  output logic [31:0]      endpoint_miss_drops
);

  localparam int SrcW = (SOURCE_BITS < OutSrcWidth) ? SOURCE_BITS : OutSrcWidth;

  state_t state, state_next;

  logic [LimitWidth-1:0] ep_limit;
  logic [LimitWidth-1:0] txn_limit;

  op_t                  op_q;
  logic [DataWidth-1:0] now_q;
  logic [SrcW-1:0]      src_q;
  logic [AddrWidth-1:0] addr_q;
  logic                 stun_q;
  logic [1:0]           kind_q;
  logic [TxUpWidth-1:0] tup_q;
  logic [TxLoWidth-1:0] tlo_q;

  ep_cmd_t  ep_cmd;
  txn_cmd_t txn_cmd;
  verdict_t v_next;
  reason_t  r_next;
  logic [SrcW-1:0] d_next;
  logic     inc_coll, inc_txid, inc_ep;

  logic [ENDPOINT_ENTRIES:0] ep_free_c, ep_hit_c;
  logic [SrcW-1:0]           ep_own_c [ENDPOINT_ENTRIES+1];
  logic [TXN_ENTRIES:0]      tx_free_c, tx_hit_c;
  logic [SrcW-1:0]           tx_src_c [TXN_ENTRIES+1];

  logic accept;
  logic cfg_write;

  assign accept    = start && !busy;
  assign busy      = (state == ST_EXEC);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ep_limit  <= EndpointLimitReset;
      txn_limit <= TxnLimitReset;
    end else if (cfg_write) begin
      if (paddr[2] == RegEndpointLimit) ep_limit <= pwdata[LimitWidth-1:0];
      else                              txn_limit <= pwdata[LimitWidth-1:0];
    end
  end

  always_comb begin
    prdata = (paddr[2] == RegEndpointLimit)
             ? {{(32-LimitWidth){1'b0}}, ep_limit}
             : {{(32-LimitWidth){1'b0}}, txn_limit};
  end

  // capture the item
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op_t'(operation);
      now_q  <= now_time;
      src_q  <= source_id[SrcW-1:0];
      addr_q <= {peer_ip, peer_port};
      stun_q <= is_stun;
      kind_q <= stun_kind;
      tup_q  <= txid_upper;
      tlo_q  <= txid_lower;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // decide the verdict and the cell commands
  always_comb begin
    state_next = state;
    ep_cmd     = '0;
    txn_cmd    = '0;
    v_next     = V_NONE;
    r_next     = R_NONE;
    d_next     = '0;
    inc_coll   = 1'b0;
    inc_txid   = 1'b0;
    inc_ep     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        case (op_q)
          OP_OUTBOUND: begin
            v_next = V_SEND;
            if (stun_q) begin
              ep_cmd.touch            = 1'b1;
              ep_cmd.touch_same_owner = 1'b1;
              if (kind_q == KindRequest) begin
                if (tx_hit_c[TXN_ENTRIES])        txn_cmd.write_hit = 1'b1;
                else if (tx_free_c[TXN_ENTRIES])  txn_cmd.claim = 1'b1;
                else                              r_next = R_FULL;
              end
            end else if (!ep_hit_c[ENDPOINT_ENTRIES]) begin
              if (ep_free_c[ENDPOINT_ENTRIES]) begin
                ep_cmd.claim = 1'b1;
              end else begin
                v_next = V_DROP;
                r_next = R_FULL;
              end
            end else if (ep_own_c[ENDPOINT_ENTRIES] != src_q) begin
              v_next   = V_DROP;
              r_next   = R_COLLISION;
              inc_coll = 1'b1;
            end else begin
              ep_cmd.touch = 1'b1;
            end
          end
          OP_INBOUND: begin
            if (stun_q && kind_q[1]) begin
              if (tx_hit_c[TXN_ENTRIES]) begin
                txn_cmd.consume = 1'b1;
                v_next = V_DELIVER;
                d_next = tx_src_c[TXN_ENTRIES];
              end else begin
                v_next   = V_DROP;
                r_next   = R_TXID_MISS;
                inc_txid = 1'b1;
              end
            end else if (ep_hit_c[ENDPOINT_ENTRIES]) begin
              ep_cmd.touch = 1'b1;
              v_next = V_DELIVER;
              d_next = ep_own_c[ENDPOINT_ENTRIES];
            end else begin
              v_next = V_DROP;
              r_next = R_EP_MISS;
              inc_ep = 1'b1;
            end
          end
          OP_GONE: ep_cmd.drop_source = 1'b1;
          OP_SWEEP: begin
            ep_cmd.age  = 1'b1;
            txn_cmd.age = 1'b1;
          end
          default: ;
        endcase
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // result registers and saturating counters
  always_ff @(posedge clk) begin
    if (rst) begin
      done                <= 1'b0;
      collision_drops     <= '0;
      txid_miss_drops     <= '0;
      endpoint_miss_drops <= '0;
    end else begin
      done <= busy;
      if (inc_coll && collision_drops != '1)     collision_drops <= collision_drops + 32'd1;
      if (inc_txid && txid_miss_drops != '1)     txid_miss_drops <= txid_miss_drops + 32'd1;
      if (inc_ep && endpoint_miss_drops != '1)
        endpoint_miss_drops <= endpoint_miss_drops + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      verdict        <= v_next;
      drop_reason    <= r_next;
      deliver_source <= OutSrcWidth'(d_next);
    end
  end

  // endpoint cell chain
  assign ep_free_c[0] = 1'b0;
  assign ep_hit_c[0]  = 1'b0;
  assign ep_own_c[0]  = '0;

  for (genvar i = 0; i < ENDPOINT_ENTRIES; i++) begin : g_ep
    udp_eo_ep_cell #(.SrcW(SrcW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (ep_cmd),
      .addr      (addr_q),
      .src       (src_q),
      .now       (now_q),
      .limit     (ep_limit),
      .free_in   (ep_free_c[i]),
      .free_out  (ep_free_c[i+1]),
      .hit_in    (ep_hit_c[i]),
      .hit_out   (ep_hit_c[i+1]),
      .owner_in  (ep_own_c[i]),
      .owner_out (ep_own_c[i+1])
    );
  end

  // transaction cell chain
  assign tx_free_c[0] = 1'b0;
  assign tx_hit_c[0]  = 1'b0;
  assign tx_src_c[0]  = '0;

  for (genvar j = 0; j < TXN_ENTRIES; j++) begin : g_txn
    udp_eo_txn_cell #(.SrcW(SrcW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (txn_cmd),
      .tx_up    (tup_q),
      .tx_lo    (tlo_q),
      .src      (src_q),
      .now      (now_q),
      .limit    (txn_limit),
      .free_in  (tx_free_c[j]),
      .free_out (tx_free_c[j+1]),
      .hit_in   (tx_hit_c[j]),
      .hit_out  (tx_hit_c[j+1]),
      .src_in   (tx_src_c[j]),
      .src_out  (tx_src_c[j+1])
    );
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted item did not start work");
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without work cycle");
  a_deliver_clean: assert property (@(posedge clk) disable iff (rst)
    done && verdict == V_DELIVER |-> drop_reason == R_NONE)
    else $error("delivery carries a drop reason");
  a_coll_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> collision_drops >= $past(collision_drops))
    else $error("collision counter went backward");
`endif

endmodule
`default_nettype wire

// ===== test/udp_endpoint_ownership_demux_tb.sv =====
`default_nettype none
module udp_endpoint_ownership_demux_tb;
  import udp_eo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EpEntries  = 64;
  localparam int TxnEntries = 32;
  localparam int AddrPool   = 80;
  localparam int TxidPool   = 48;
  localparam int PhaseItems = 210;
  localparam int Phases     = 5;

  typedef struct {
    op_t         op;
    logic [31:0] now;
    logic [7:0]  src;
    logic [31:0] ip;
    logic [15:0] port;
    logic        stun;
    logic [1:0]  kind;
    logic [31:0] tup;
    logic [63:0] tlo;
  } pkt_t;

  typedef struct {
    verdict_t    verdict;
    reason_t     reason;
    logic [7:0]  dsrc;
    logic [31:0] coll;
    logic [31:0] txmiss;
    logic [31:0] epmiss;
  } route_t;

  typedef struct {
    pkt_t     pkt;
    verdict_t verdict;
    reason_t  reason;
    logic [7:0] dsrc;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [1:0] operation = '0;
  logic [31:0] now_time = '0;
  logic [7:0] source_id = '0;
  logic [31:0] peer_ip = '0;
  logic [15:0] peer_port = '0;
  logic is_stun = 1'b0;
  logic [1:0] stun_kind = '0;
  logic [31:0] txid_upper = '0;
  logic [63:0] txid_lower = '0;
  logic done;
  logic [1:0] verdict;
  logic [2:0] drop_reason;
  logic [7:0] deliver_source;
  logic [31:0] collision_drops, txid_miss_drops, endpoint_miss_drops;

  udp_endpoint_ownership_demux dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .operation, .now_time, .source_id, .peer_ip, .peer_port,
    .is_stun, .stun_kind, .txid_upper, .txid_lower, .done, .verdict,
    .drop_reason, .deliver_source, .collision_drops, .txid_miss_drops,
    .endpoint_miss_drops
  );

  always #6 clk = ~clk;

  initial begin
    #5ms;
    $display("udp_endpoint_ownership_demux: mismatch");
    $finish;
  end

  // shadow tables and limits
  logic [15:0] ep_limit, txn_limit;
  logic        ep_vld [EpEntries];
  logic [47:0] ep_addr [EpEntries];
  logic [7:0]  ep_own [EpEntries];
  logic [31:0] ep_seen [EpEntries];
  logic        tx_vld [TxnEntries];
  logic [95:0] tx_id [TxnEntries];
  logic [7:0]  tx_src [TxnEntries];
  logic [31:0] tx_born [TxnEntries];
  logic [31:0] coll_cnt, txmiss_cnt, epmiss_cnt;

  route_t   route_q[$];
  dir_row_t dir_q[$];
  int       errors = 0;
  logic [31:0] addr_ip [AddrPool];
  logic [15:0] addr_port [AddrPool];
  logic [95:0] txid_vals [TxidPool];

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic int ep_lookup(logic [47:0] a);
    for (int i = 0; i < EpEntries; i++)
      if (ep_vld[i] && ep_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic int txn_lookup(logic [95:0] id);
    for (int i = 0; i < TxnEntries; i++)
      if (tx_vld[i] && tx_id[i] == id) return i;
    return -1;
  endfunction

  // compute the routing of one packet and update the shadow tables
  function automatic route_t route_packet(pkt_t p);
    route_t r;
    logic [47:0] a;
    logic [95:0] id;
    int e, t;
    r.verdict = V_NONE;
    r.reason = R_NONE;
    r.dsrc = '0;
    a = {p.ip, p.port};
    id = {p.tup, p.tlo};
    case (p.op)
      OP_OUTBOUND: begin
        r.verdict = V_SEND;
        e = ep_lookup(a);
        if (p.stun) begin
          if (p.kind == KindRequest) begin
            t = txn_lookup(id);
            if (t < 0)
              for (int i = 0; i < TxnEntries; i++)
                if (!tx_vld[i]) begin
                  t = i;
                  break;
                end
            if (t >= 0) begin
              tx_vld[t] = 1'b1;
              tx_id[t] = id;
              tx_src[t] = p.src;
              tx_born[t] = p.now;
            end else begin
              r.reason = R_FULL;
            end
          end
          if (e >= 0 && ep_own[e] == p.src) ep_seen[e] = p.now;
        end else if (e < 0) begin
          for (int i = 0; i < EpEntries; i++)
            if (!ep_vld[i]) begin
              e = i;
              break;
            end
          if (e >= 0) begin
            ep_vld[e] = 1'b1;
            ep_addr[e] = a;
            ep_own[e] = p.src;
            ep_seen[e] = p.now;
          end else begin
            r.verdict = V_DROP;
            r.reason = R_FULL;
          end
        end else if (ep_own[e] != p.src) begin
          coll_cnt = sat_inc(coll_cnt);
          r.verdict = V_DROP;
          r.reason = R_COLLISION;
        end else begin
          ep_seen[e] = p.now;
        end
      end
      OP_INBOUND: begin
        if (p.stun && p.kind >= 2'd2) begin
          t = txn_lookup(id);
          if (t >= 0) begin
            tx_vld[t] = 1'b0;
            r.verdict = V_DELIVER;
            r.dsrc = tx_src[t];
          end else begin
            txmiss_cnt = sat_inc(txmiss_cnt);
            r.verdict = V_DROP;
            r.reason = R_TXID_MISS;
          end
        end else begin
          e = ep_lookup(a);
          if (e >= 0) begin
            ep_seen[e] = p.now;
            r.verdict = V_DELIVER;
            r.dsrc = ep_own[e];
          end else begin
            epmiss_cnt = sat_inc(epmiss_cnt);
            r.verdict = V_DROP;
            r.reason = R_EP_MISS;
          end
        end
      end
      OP_GONE: begin
        for (int i = 0; i < EpEntries; i++)
          if (ep_vld[i] && ep_own[i] == p.src) ep_vld[i] = 1'b0;
      end
      default: begin
        for (int i = 0; i < EpEntries; i++)
          if (ep_vld[i] && (p.now - ep_seen[i]) > {16'd0, ep_limit}) ep_vld[i] = 1'b0;
        for (int i = 0; i < TxnEntries; i++)
          if (tx_vld[i] && (p.now - tx_born[i]) > {16'd0, txn_limit}) tx_vld[i] = 1'b0;
      end
    endcase
    r.coll = coll_cnt;
    r.txmiss = txmiss_cnt;
    r.epmiss = epmiss_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // check every result strobe against the oldest expectation
  always @(posedge clk) begin
    route_t w;
    if (!rst && done) begin
      if (route_q.size() == 0) begin
        report_mismatch("result with nothing pending", {30'd0, verdict}, '0);
      end else begin
        w = route_q.pop_front();
        if (verdict !== w.verdict) report_mismatch("verdict", verdict, w.verdict);
        if (drop_reason !== w.reason) report_mismatch("drop_reason", drop_reason, w.reason);
        if (deliver_source !== w.dsrc) report_mismatch("deliver_source", deliver_source, w.dsrc);
        if (collision_drops !== w.coll) report_mismatch("collision_drops", collision_drops, w.coll);
        if (txid_miss_drops !== w.txmiss)
          report_mismatch("txid_miss_drops", txid_miss_drops, w.txmiss);
        if (endpoint_miss_drops !== w.epmiss)
          report_mismatch("endpoint_miss_drops", endpoint_miss_drops, w.epmiss);
      end
    end
  end

  // hold the packet until the block takes it, then predict
  task automatic send_packet(pkt_t p, bit typed, verdict_t v, reason_t rs, logic [7:0] ds);
    route_t r;
    start <= 1'b1;
    operation <= p.op;
    now_time <= p.now;
    source_id <= p.src;
    peer_ip <= p.ip;
    peer_port <= p.port;
    is_stun <= p.stun;
    stun_kind <= p.kind;
    txid_upper <= p.tup;
    txid_lower <= p.tlo;
    do @(posedge clk); while (busy);
    r = route_packet(p);
    if (typed) begin
      r.verdict = v;
      r.reason = rs;
      r.dsrc = ds;
    end
    route_q.push_back(r);
  endtask

  task automatic reg_write(logic idx, logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegEndpointLimit) ep_limit = val;
    else txn_limit = val;
  endtask

  // stop sending and let every pending result drain
  task automatic drain();
    start <= 1'b0;
    while (route_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic pkt_t mk(op_t op, logic [31:0] now, logic [7:0] src, logic [31:0] ip,
                              logic [15:0] port, logic stun, logic [1:0] kind,
                              logic [95:0] id);
    pkt_t p;
    p.op = op;
    p.now = now;
    p.src = src;
    p.ip = ip;
    p.port = port;
    p.stun = stun;
    p.kind = kind;
    {p.tup, p.tlo} = id;
    return p;
  endfunction

  function automatic void add_row(pkt_t p, verdict_t v, reason_t rs, logic [7:0] ds);
    dir_row_t d;
    d.pkt = p;
    d.verdict = v;
    d.reason = rs;
    d.dsrc = ds;
    dir_q.push_back(d);
  endfunction

  function automatic pkt_t random_packet(logic [31:0] now);
    pkt_t p;
    int k, n;
    k = $urandom_range(0, 99);
    p.op = (k < 40) ? OP_OUTBOUND : (k < 78) ? OP_INBOUND : (k < 83) ? OP_GONE : OP_SWEEP;
    p.now = now;
    p.src = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 5)) : 8'($urandom);
    if ($urandom_range(0, 99) < 88) begin
      n = $urandom_range(0, AddrPool - 1);
      p.ip = addr_ip[n];
      p.port = addr_port[n];
    end else begin
      p.ip = $urandom;
      p.port = 16'($urandom);
    end
    p.stun = ($urandom_range(0, 99) < 45);
    p.kind = 2'($urandom);
    if ($urandom_range(0, 99) < 88) begin
      {p.tup, p.tlo} = txid_vals[$urandom_range(0, TxidPool - 1)];
    end else begin
      p.tup = $urandom;
      p.tlo = {$urandom, $urandom};
    end
    return p;
  endfunction

  initial begin
    logic [95:0] t1, t2, ones;
    logic [31:0] a_ip, b_ip, now;
    logic [15:0] lim0 [Phases], lim1 [Phases];
    int sent, pct;

    // reset state of the shadow model
    ep_limit = EndpointLimitReset;
    txn_limit = TxnLimitReset;
    coll_cnt = '0;
    txmiss_cnt = '0;
    epmiss_cnt = '0;
    foreach (ep_vld[i]) ep_vld[i] = 1'b0;
    foreach (tx_vld[i]) tx_vld[i] = 1'b0;
    foreach (addr_ip[i]) begin
      addr_ip[i] = $urandom;
      addr_port[i] = 16'($urandom);
    end
    foreach (txid_vals[i]) txid_vals[i] = {$urandom, $urandom, $urandom};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: claim, collision, delivery, txid routing, extremes, source gone, aging
    t1 = 96'h1234_5678_9ABC_DEF0_1357_2468;
    t2 = 96'h0F0F_0F0F_F0F0_F0F0_5555_AAAA;
    ones = '1;
    a_ip = 32'h0A00_0001;
    b_ip = 32'hC0A8_0101;
    add_row(mk(OP_INBOUND, 10, 0, a_ip, 5000, 0, 0, t1), V_DROP, R_EP_MISS, 0);
    add_row(mk(OP_OUTBOUND, 10, 3, a_ip, 5000, 0, 0, t1), V_SEND, R_NONE, 0);
    add_row(mk(OP_OUTBOUND, 10, 4, a_ip, 5000, 0, 0, t1), V_DROP, R_COLLISION, 0);
    add_row(mk(OP_INBOUND, 10, 0, a_ip, 5000, 0, 0, t1), V_DELIVER, R_NONE, 3);
    add_row(mk(OP_OUTBOUND, 10, 7, a_ip, 5000, 1, 0, t1), V_SEND, R_NONE, 0);
    add_row(mk(OP_OUTBOUND, 10, 9, b_ip, 3478, 1, 0, t1), V_SEND, R_NONE, 0);
    add_row(mk(OP_INBOUND, 10, 0, b_ip, 3478, 1, 2, t1), V_DELIVER, R_NONE, 9);
    add_row(mk(OP_INBOUND, 10, 0, b_ip, 3478, 1, 3, t1), V_DROP, R_TXID_MISS, 0);
    add_row(mk(OP_OUTBOUND, 10, 3, a_ip, 5000, 1, 1, t2), V_SEND, R_NONE, 0);
    add_row(mk(OP_INBOUND, 10, 0, a_ip, 5000, 1, 0, t2), V_DELIVER, R_NONE, 3);
    add_row(mk(OP_INBOUND, 10, 0, b_ip, 3478, 1, 1, t2), V_DROP, R_EP_MISS, 0);
    add_row(mk(OP_OUTBOUND, '1, '1, '1, '1, 0, 0, ones), V_SEND, R_NONE, 0);
    add_row(mk(OP_OUTBOUND, 0, 0, 0, 0, 0, 0, '0), V_SEND, R_NONE, 0);
    add_row(mk(OP_INBOUND, '1, 0, '1, '1, 0, 3, ones), V_DELIVER, R_NONE, 8'hFF);
    add_row(mk(OP_OUTBOUND, 10, '1, b_ip, 3478, 1, 0, ones), V_SEND, R_NONE, 0);
    add_row(mk(OP_INBOUND, 10, 0, b_ip, 3478, 1, 2, ones), V_DELIVER, R_NONE, 8'hFF);
    add_row(mk(OP_OUTBOUND, 10, 1, b_ip, 3478, 1, 0, '0), V_SEND, R_NONE, 0);
    add_row(mk(OP_GONE, 10, '1, 0, 0, 0, 0, '0), V_NONE, R_NONE, 0);
    add_row(mk(OP_INBOUND, 10, 0, '1, '1, 0, 0, '0), V_DROP, R_EP_MISS, 0);
    add_row(mk(OP_SWEEP, 100, 0, 0, 0, 0, 0, '0), V_NONE, R_NONE, 0);
    add_row(mk(OP_INBOUND, 100, 0, a_ip, 5000, 0, 0, '0), V_DROP, R_EP_MISS, 0);
    add_row(mk(OP_INBOUND, 100, 0, 0, 0, 1, 2, '0), V_DROP, R_TXID_MISS, 0);
    foreach (dir_q[i]) begin
      send_packet(dir_q[i].pkt, 1'b1, dir_q[i].verdict, dir_q[i].reason, dir_q[i].dsrc);
      if ($urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
    drain();

    // random phases, each under its own pair of limits
    lim0 = '{16'd30, 16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(1, 65535))};
    lim1 = '{16'd40, 16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(1, 65535))};
    sent = 0;
    now = 200;
    for (int ph = 0; ph < Phases; ph++) begin
      if (ph != 0) begin
        reg_write(RegEndpointLimit, lim0[ph]);
        reg_write(RegTxnLimit, lim1[ph]);
      end
      if (ph == 3) now = 32'hFFFF_FF00;
      for (int n = 0; n < PhaseItems; n++) begin
        pct = (sent < PhaseItems * Phases / 3) ? 7 :
              (sent < 2 * PhaseItems * Phases / 3) ? 82 : 0;
        if ($urandom_range(0, 99) < 3) now += $urandom_range(0, 100000);
        else now += $urandom_range(0, 2);
        send_packet(random_packet(now), 1'b0, V_NONE, R_NONE, '0);
        sent++;
        if ($urandom_range(0, 99) < pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("udp_endpoint_ownership_demux: match");
    end else begin
      $display("udp_endpoint_ownership_demux: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/udp_eo_pkg.sv
rtl/core/udp_eo_ep_cell.sv
rtl/core/udp_eo_txn_cell.sv
rtl/core/udp_endpoint_ownership_demux.sv
test/udp_endpoint_ownership_demux_tb.sv
